// ----- hw/rtl/nddi_pkg.sv -----
`timescale 1ns / 1ps

package nddi_pkg;

  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned WORD_BITS  = 32;

  localparam int unsigned IDX_BITS  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_BITS  = $clog2(MAX_POINTS + 1);
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;
  localparam int unsigned SUM_BITS  = 2 * WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SUM_BITS-1:0]  wide_t;
  typedef logic        [PROD_BITS-1:0] mag_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_READY = 2'd1;
  localparam logic [1:0] STAT_TOO_MANY  = 2'd2;
  localparam logic [1:0] STAT_DUPLICATE = 2'd3;

  typedef struct packed {
    logic start;
    logic neg;
    mag_t mag;
    mag_t den;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    word_t quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUP_RD,
    ST_DUP_CMP,
    ST_DD_RD,
    ST_DD_SUB,
    ST_MUL,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV,
    ST_EV_RD,
    ST_EV_ACC,
    ST_EV_STEP_RD,
    ST_EV_SUB,
    ST_EV_SHR,
    ST_EV_ADD,
    ST_DONE
  } state_t;

  // Saturates a wide signed value to one word.
  function automatic word_t clamp_word(input wide_t v);
    if (v > wide_t'(WORD_MAX)) return WORD_MAX;
    if (v < wide_t'(WORD_MIN)) return WORD_MIN;
    return v[WORD_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/nddi_div.sv -----
`timescale 1ns / 1ps

module nddi_div (
  input  logic                clk,
  input  logic                rst_n,
  input  nddi_pkg::div_req_t  req,
  output nddi_pkg::div_rsp_t  rsp
);
  import nddi_pkg::*;

  localparam int unsigned STEP_BITS = $clog2(WORD_BITS);

  logic                  busy_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  neg_r;
  mag_t                  rem_r;
  mag_t                  den_r;
  logic [WORD_BITS-1:0]  lo_r;
  logic [WORD_BITS-1:0]  quo_bits_r;
  word_t                 quo_r;

  mag_t                  hi_part;
  logic [PROD_BITS:0]    trial;
  logic                  take;
  logic [WORD_BITS-1:0]  quo_nxt;
  logic                  last_step;

  // The dividend is mag shifted up by the fraction bits; its upper part must stay
  // below the divisor, or the quotient cannot fit and saturates at once.
  assign hi_part   = req.mag >> (WORD_BITS - FRAC_BITS);
  assign trial     = {rem_r, lo_r[WORD_BITS-1]};
  assign take      = trial >= {1'b0, den_r};
  assign quo_nxt   = {quo_bits_r[WORD_BITS-2:0], take};
  assign last_step = step_r == STEP_BITS'(WORD_BITS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= (req.mag != '0) && (req.den != '0) && (hi_part < req.den);
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r      <= req.neg;
      den_r      <= req.den;
      rem_r      <= hi_part;
      lo_r       <= {req.mag[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo_bits_r <= '0;
      if (req.mag == '0) begin
        quo_r <= '0;
      end else if (req.den == '0 || hi_part >= req.den) begin
        quo_r <= req.neg ? WORD_MIN : WORD_MAX;
      end
    end else if (busy_r) begin
      rem_r      <= take ? PROD_BITS'(trial - {1'b0, den_r}) : trial[PROD_BITS-1:0];
      lo_r       <= lo_r << 1;
      quo_bits_r <= quo_nxt;
      if (last_step) begin
        if (quo_nxt[WORD_BITS-1]) begin
          quo_r <= neg_r ? WORD_MIN : WORD_MAX;
        end else begin
          quo_r <= neg_r ? word_t'(-quo_nxt) : word_t'(quo_nxt);
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- hw/rtl/newton_divided_difference_interpolator_unit.sv -----
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      func, x_re, x_im, y_re, y_im, last_point
// out_     output     out_valid / out_ready    status, value_re, value_im, points_held
//
// A fit checks every pair of held points for a duplicate and then works out the n(n-1)/2
// divided differences, limited by the bit-serial dividers. An evaluation makes one pass
// through the shared multiplier per coefficient after the top one. One item is in work
// at a time.
// Reset clears the point count and the fit flag; the point stores are not cleared.
// A result waiting on out_ready holds the sequencer in its final state.
`timescale 1ns / 1ps

module newton_divided_difference_interpolator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic signed [nddi_pkg::WORD_BITS-1:0] in_x_re,
  input  logic signed [nddi_pkg::WORD_BITS-1:0] in_x_im,
  input  logic signed [nddi_pkg::WORD_BITS-1:0] in_y_re,
  input  logic signed [nddi_pkg::WORD_BITS-1:0] in_y_im,
  input  logic                                 in_last_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [1:0]                    out_status,
  output logic signed [nddi_pkg::WORD_BITS-1:0] out_value_re,
  output logic signed [nddi_pkg::WORD_BITS-1:0] out_value_im,
  output logic        [nddi_pkg::CNT_BITS-1:0]  out_points_held
);
  import nddi_pkg::*;

  localparam logic [2:0] MUL_LAST_CMUL = 3'd3;
  localparam logic [2:0] MUL_LAST_CDIV = 3'd5;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r;
  logic                  ready_r;
  logic [1:0]            status_r;
  logic                  val_sel_r;
  logic [IDX_BITS-1:0]   i_r, k_r;
  word_t                 x_re_r, x_im_r;
  word_t                 a_re_r, a_im_r, b_re_r, b_im_r;
  word_t                 t_re_r, t_im_r, cl_re_r, cl_im_r;
  logic signed [PROD_BITS-1:0] prod_r [6];
  logic [2:0]            m_r;
  logic                  div_mode_r;
  logic                  nre_neg_r, nim_neg_r;
  mag_t                  nre_mag_r, nim_mag_r, den_r;

  logic [PROD_BITS-1:0]  sup_mem  [MAX_POINTS];
  logic [PROD_BITS-1:0]  coef_mem [MAX_POINTS];
  logic [PROD_BITS-1:0]  sa_q_r, sb_q_r, ca_q_r, cb_q_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  word_t                 out_value_re_r, out_value_im_r;
  logic [CNT_BITS-1:0]   out_points_r;

  logic                  accept;
  logic                  is_load;
  logic [CNT_BITS-1:0]   load_base, load_n;
  logic                  load_room;
  logic [IDX_BITS-1:0]   last_idx;
  logic [IDX_BITS-1:0]   sb_addr;
  word_t                 sa_re, sa_im, sb_re, sb_im, ca_re, ca_im, cb_re, cb_im;
  logic                  dup_hit, dup_last_k, dup_last_i, dd_last_i, dd_last_j;
  logic [2:0]            m_last;
  word_t                 opa, opb;
  logic signed [PROD_BITS-1:0] mul_p;
  wide_t                 cm_re, cm_im, dv_re, dv_im, nre_abs, nim_abs;
  mag_t                  den_sum;
  logic                  out_free;
  logic                  coef_we;
  logic [IDX_BITS-1:0]   coef_waddr;
  logic [PROD_BITS-1:0]  coef_wdata;
  div_req_t              req_re, req_im;
  div_rsp_t              rsp_re, rsp_im;
  logic                  div_done;

  assign accept    = in_valid && in_ready;
  assign is_load   = in_func == FUNC_LOAD;
  assign load_base = ready_r ? '0 : count_r;
  assign load_room = load_base < CNT_BITS'(MAX_POINTS);
  assign load_n    = load_room ? CNT_BITS'(load_base + 1'b1) : load_base;
  assign last_idx  = IDX_BITS'(count_r - 1'b1);
  assign out_free  = !out_valid_r || out_ready;

  assign sa_re = word_t'(sa_q_r[PROD_BITS-1:WORD_BITS]);
  assign sa_im = word_t'(sa_q_r[WORD_BITS-1:0]);
  assign sb_re = word_t'(sb_q_r[PROD_BITS-1:WORD_BITS]);
  assign sb_im = word_t'(sb_q_r[WORD_BITS-1:0]);
  assign ca_re = word_t'(ca_q_r[PROD_BITS-1:WORD_BITS]);
  assign ca_im = word_t'(ca_q_r[WORD_BITS-1:0]);
  assign cb_re = word_t'(cb_q_r[PROD_BITS-1:WORD_BITS]);
  assign cb_im = word_t'(cb_q_r[WORD_BITS-1:0]);

  assign dup_hit    = sa_q_r == sb_q_r;
  assign dup_last_k = IDX_BITS'(k_r + 1'b1) == i_r;
  assign dup_last_i = CNT_BITS'({1'b0, i_r} + 1'b1) == count_r;
  assign dd_last_i  = i_r == k_r;
  assign dd_last_j  = CNT_BITS'({1'b0, k_r} + 1'b1) == count_r;
  assign m_last     = div_mode_r ? MUL_LAST_CDIV : MUL_LAST_CMUL;
  assign div_done   = !rsp_re.busy && !rsp_im.busy;

  // One shared multiplier; the step picks the operand pair.
  always_comb begin
    unique case (m_r)
      3'd0:    begin opa = a_re_r; opb = b_re_r; end
      3'd1:    begin opa = a_im_r; opb = b_im_r; end
      3'd2:    begin opa = a_re_r; opb = b_im_r; end
      3'd3:    begin opa = a_im_r; opb = b_re_r; end
      3'd4:    begin opa = b_re_r; opb = b_re_r; end
      3'd5:    begin opa = b_im_r; opb = b_im_r; end
      default: begin opa = '0;     opb = '0;     end
    endcase
  end

  assign mul_p = opa * opb;

  assign cm_re   = wide_t'(prod_r[0]) - wide_t'(prod_r[1]);
  assign cm_im   = wide_t'(prod_r[2]) + wide_t'(prod_r[3]);
  assign dv_re   = wide_t'(prod_r[0]) + wide_t'(prod_r[1]);
  assign dv_im   = wide_t'(prod_r[3]) - wide_t'(prod_r[2]);
  assign nre_abs = dv_re < 0 ? -dv_re : dv_re;
  assign nim_abs = dv_im < 0 ? -dv_im : dv_im;
  assign den_sum = $unsigned(prod_r[4]) + $unsigned(prod_r[5]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_load) begin
            state_nxt = (in_last_point && load_n > CNT_BITS'(1)) ? ST_DUP_RD : ST_DONE;
          end else begin
            state_nxt = ready_r ? ST_EV_RD : ST_DONE;
          end
        end
      end
      ST_DUP_RD:  state_nxt = ST_DUP_CMP;
      ST_DUP_CMP: begin
        priority if (dup_hit)                  state_nxt = ST_DONE;
        else if (dup_last_k && dup_last_i)     state_nxt = ST_DD_RD;
        else                                   state_nxt = ST_DUP_RD;
      end
      ST_DD_RD:   state_nxt = ST_DD_SUB;
      ST_DD_SUB:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (m_r == m_last) begin
          state_nxt = div_mode_r ? ST_NUM : ST_EV_SHR;
        end
      end
      ST_NUM:     state_nxt = ST_DIV_GO;
      ST_DIV_GO:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (dd_last_i && dd_last_j) ? ST_DONE : ST_DD_RD;
        end
      end
      ST_EV_RD:      state_nxt = ST_EV_ACC;
      ST_EV_ACC:     state_nxt = (i_r == '0) ? ST_DONE : ST_EV_STEP_RD;
      ST_EV_STEP_RD: state_nxt = ST_EV_SUB;
      ST_EV_SUB:     state_nxt = ST_MUL;
      ST_EV_SHR:     state_nxt = ST_EV_ADD;
      ST_EV_ADD:     state_nxt = (i_r == '0) ? ST_DONE : ST_EV_STEP_RD;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready   = state_r == ST_IDLE;
    sb_addr    = (state_r == ST_DD_RD) ? IDX_BITS'(i_r - k_r) : k_r;
    coef_we    = 1'b0;
    coef_waddr = i_r;
    coef_wdata = {rsp_re.quo, rsp_im.quo};
    if (state_r == ST_IDLE && accept && is_load && load_room) begin
      coef_we    = 1'b1;
      coef_waddr = load_base[IDX_BITS-1:0];
      coef_wdata = {in_y_re, in_y_im};
    end else if (state_r == ST_DIV && div_done) begin
      coef_we    = 1'b1;
    end
    req_re = '{start: state_r == ST_DIV_GO, neg: nre_neg_r, mag: nre_mag_r, den: den_r};
    req_im = '{start: state_r == ST_DIV_GO, neg: nim_neg_r, mag: nim_mag_r, den: den_r};
  end

  nddi_div u_div_re (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_re),
    .rsp   (rsp_re)
  );

  nddi_div u_div_im (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_im),
    .rsp   (rsp_im)
  );

  // Point stores, read every cycle; the read data are registered and appear in the cycle after the address.
  always_ff @(posedge clk) begin
    if (accept && is_load && load_room) begin
      sup_mem[load_base[IDX_BITS-1:0]] <= {in_x_re, in_x_im};
    end
    sa_q_r <= sup_mem[i_r];
    sb_q_r <= sup_mem[sb_addr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    ca_q_r <= coef_mem[i_r];
    cb_q_r <= coef_mem[IDX_BITS'(i_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && accept && is_load) begin
        count_r <= load_n;
        ready_r <= in_last_point && load_n == CNT_BITS'(1);
      end else if (state_r == ST_DUP_CMP && dup_hit) begin
        count_r <= '0;
        ready_r <= 1'b0;
      end else if (state_r == ST_DIV && div_done && dd_last_i && dd_last_j) begin
        ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_re_r    <= in_x_re;
          x_im_r    <= in_x_im;
          val_sel_r <= !is_load && ready_r;
          k_r       <= '0;
          if (is_load) begin
            status_r <= load_room ? STAT_OK : STAT_TOO_MANY;
            i_r      <= IDX_BITS'(1);
          end else begin
            status_r <= ready_r ? STAT_OK : STAT_NOT_READY;
            i_r      <= last_idx;
          end
        end
      end
      ST_DUP_CMP: begin
        priority if (dup_hit) begin
          status_r <= STAT_DUPLICATE;
        end else if (dup_last_k && dup_last_i) begin
          i_r <= last_idx;
          k_r <= IDX_BITS'(1);
        end else if (dup_last_k) begin
          i_r <= i_r + 1'b1;
          k_r <= '0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      ST_DD_SUB: begin
        a_re_r     <= clamp_word(wide_t'(ca_re) - wide_t'(cb_re));
        a_im_r     <= clamp_word(wide_t'(ca_im) - wide_t'(cb_im));
        b_re_r     <= clamp_word(wide_t'(sa_re) - wide_t'(sb_re));
        b_im_r     <= clamp_word(wide_t'(sa_im) - wide_t'(sb_im));
        m_r        <= '0;
        div_mode_r <= 1'b1;
      end
      ST_MUL: begin
        prod_r[m_r] <= mul_p;
        m_r         <= m_r + 1'b1;
      end
      ST_NUM: begin
        nre_neg_r <= dv_re < 0;
        nim_neg_r <= dv_im < 0;
        nre_mag_r <= nre_abs[PROD_BITS-1:0];
        nim_mag_r <= nim_abs[PROD_BITS-1:0];
        den_r     <= den_sum;
      end
      ST_DIV: begin
        if (div_done) begin
          if (dd_last_i) begin
            i_r <= last_idx;
            k_r <= k_r + 1'b1;
          end else begin
            i_r <= i_r - 1'b1;
          end
        end
      end
      ST_EV_ACC: begin
        a_re_r <= ca_re;
        a_im_r <= ca_im;
        if (i_r != '0) begin
          i_r <= i_r - 1'b1;
        end
      end
      ST_EV_SUB: begin
        b_re_r     <= clamp_word(wide_t'(x_re_r) - wide_t'(sa_re));
        b_im_r     <= clamp_word(wide_t'(x_im_r) - wide_t'(sa_im));
        cl_re_r    <= ca_re;
        cl_im_r    <= ca_im;
        m_r        <= '0;
        div_mode_r <= 1'b0;
      end
      ST_EV_SHR: begin
        // Arithmetic shift truncates toward minus infinity.
        t_re_r <= clamp_word(cm_re >>> FRAC_BITS);
        t_im_r <= clamp_word(cm_im >>> FRAC_BITS);
      end
      ST_EV_ADD: begin
        a_re_r <= clamp_word(wide_t'(t_re_r) + wide_t'(cl_re_r));
        a_im_r <= clamp_word(wide_t'(t_im_r) + wide_t'(cl_im_r));
        if (i_r != '0) begin
          i_r <= i_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_status_r   <= status_r;
          out_value_re_r <= val_sel_r ? a_re_r : '0;
          out_value_im_r <= val_sel_r ? a_im_r : '0;
          out_points_r   <= count_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_re    = out_value_re_r;
  assign out_value_im    = out_value_im_r;
  assign out_points_held = out_points_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_POINTS))
    else $error("point count above capacity");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> count_r != '0)
    else $error("fit flagged ready with no points");

  a_dup_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUP_CMP && dup_hit) |=>
      (count_r == '0 && !ready_r && state_r == ST_DONE && status_r == STAT_DUPLICATE))
    else $error("duplicate point did not discard the set");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && out_status_r == $past(status_r)))
    else $error("result transfer lost its status");

endmodule
